### sv/jof_pkg.sv
// shared types and constants of the json object framer
package jof_pkg;

	localparam logic [7:0] CH_OPEN   = 8'h7B;
	localparam logic [7:0] CH_CLOSE  = 8'h7D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam int MSG_W = 16;
	localparam logic [MSG_W-1:0] MSG_MAX_RESET = 16'd4096;

	typedef enum logic [2:0] {
		CL_OPEN,
		CL_CLOSE,
		CL_BSLASH,
		CL_QUOTE,
		CL_SKIP,
		CL_OTHER
	} byte_class_t;

	typedef enum logic [1:0] {
		ST_PENDING = 2'd0,
		ST_DONE    = 2'd1,
		ST_BAD     = 2'd2,
		ST_LONG    = 2'd3
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [MSG_W-1:0]   msg_length;
	} result_t;

	function automatic byte_class_t classify(input logic [7:0] b);
		byte_class_t c;
		unique case (b)
			CH_OPEN:   c = CL_OPEN;
			CH_CLOSE:  c = CL_CLOSE;
			CH_BSLASH: c = CL_BSLASH;
			CH_QUOTE:  c = CL_QUOTE;
			CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_NUL: c = CL_SKIP;
			default:   c = CL_OTHER;
		endcase
		return c;
	endfunction

endpackage

### sv/json_object_framer_unit.sv
// top level of the json object framer: front stage, class queue, framing state, result queue
// path: a byte's class is registered in the front stage and then in the class queue, and its result in the result queue
// throughput: one byte per cycle sustained while the consumer keeps popping, set by the state update in the back part
// each transfer in gives exactly one result transfer out, in order
// reset (arst_n low, asynchronous): queues empty, framing state idle, msg_max back to 4096
module json_object_framer_unit #(
	parameter int DEPTH_BITS  = 8,
	parameter int LEN_BITS    = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// byte input, queue style
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                data_byte,
	// result output, queue style
	output logic                      empty,
	input  logic                      pop,
	output logic [1:0]                status,
	output logic [jof_pkg::MSG_W-1:0] msg_length,
	// message length limit register
	input  logic                      msg_max_we,
	input  logic [jof_pkg::MSG_W-1:0] msg_max_wdata
);
	import jof_pkg::*;

	localparam int RES_W = $bits(result_t);
	localparam int CLS_W = $bits(byte_class_t);

	// front stage to class queue
	logic        fq_push, fq_full;
	byte_class_t fq_wcls;
	// class queue to back part
	logic             fq_empty, fq_pop;
	logic [CLS_W-1:0] fq_rdata;
	// back part to result queue
	logic             rq_push, rq_full;
	result_t          rq_wres, rq_rres;
	logic [RES_W-1:0] rq_rdata;

	// front: classify each byte and hold it for one stage
	jof_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.full      (full),
		.cls_valid (fq_push),
		.cls       (fq_wcls),
		.cls_full  (fq_full)
	);

	// short queue of classes lets front and back stall apart
	jof_fifo #(
		.WIDTH (CLS_W),
		.DEPTH (QUEUE_DEPTH)
	) u_cls_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  (fq_wcls),
		.full   (fq_full),
		.pop    (fq_pop),
		.rdata  (fq_rdata),
		.empty  (fq_empty)
	);

	// back: one class per cycle into the framing state machine while classes wait and results fit
	jof_back #(
		.DEPTH_BITS (DEPTH_BITS),
		.LEN_BITS   (LEN_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg_max_we    (msg_max_we),
		.msg_max_wdata (msg_max_wdata),
		.cls_empty     (fq_empty),
		.cls           (byte_class_t'(fq_rdata)),
		.cls_pop       (fq_pop),
		.res_full      (rq_full),
		.res_push      (rq_push),
		.res           (rq_wres)
	);

	// result queue: results wait here while the consumer stalls
	jof_fifo #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_wres),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign rq_rres    = result_t'(rq_rdata);
	assign status     = rq_rres.status;
	assign msg_length = rq_rres.msg_length;
endmodule

### sv/jof_fifo.sv
// small register queue with push/full and pop/empty sides
module jof_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

### sv/jof_front.sv
// input stage: accepts bytes and registers their character class
module jof_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [7:0]           data_byte,
	output logic                 full,
	output logic                 cls_valid,
	output jof_pkg::byte_class_t cls,
	input  logic                 cls_full
);
	import jof_pkg::*;

	logic        valid_s1;
	byte_class_t class_s1;
	logic        advance;

	// stage moves on when empty or when the queue takes its entry
	assign advance   = !valid_s1 || !cls_full;
	assign full      = !advance;
	assign cls_valid = valid_s1;
	assign cls       = class_s1;

	always_ff @(posedge clk) begin
		if (advance && push) begin
			class_s1 <= classify(data_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end
endmodule

### sv/jof_back.sv
// framing state: brace depth, string and escape tracking, byte count
module jof_back #(
	parameter int DEPTH_BITS = 8,
	parameter int LEN_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         msg_max_we,
	input  logic [jof_pkg::MSG_W-1:0]    msg_max_wdata,
	input  logic                         cls_empty,
	input  jof_pkg::byte_class_t         cls,
	output logic                         cls_pop,
	input  logic                         res_full,
	output logic                         res_push,
	output jof_pkg::result_t             res
);
	import jof_pkg::*;

	localparam int CW = (LEN_BITS > MSG_W) ? LEN_BITS : MSG_W;

	logic                  in_object_q, in_string_q, escape_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [LEN_BITS-1:0]   count_q;
	logic [MSG_W-1:0]      msg_max_q;

	logic                  go;
	logic [LEN_BITS-1:0]   count_nx;
	logic [CW-1:0]         count_ext, max_ext;
	status_t               st;
	logic                  obj_nx, str_nx, esc_nx;
	logic [DEPTH_BITS-1:0] depth_nx;

	assign go       = !cls_empty && !res_full;
	assign cls_pop  = go;
	assign res_push = go;

	// saturating count, this byte included
	assign count_nx  = (count_q == '1) ? count_q : count_q + LEN_BITS'(1);
	assign count_ext = CW'(count_nx);
	assign max_ext   = CW'(msg_max_q);

	always_comb begin
		st       = ST_PENDING;
		obj_nx   = in_object_q;
		str_nx   = in_string_q;
		esc_nx   = escape_q;
		depth_nx = depth_q;
		unique case (cls)
			CL_OPEN: begin
				obj_nx = 1'b1;
				esc_nx = 1'b0;
				if (!in_string_q) begin
					if (depth_q == '1) begin
						st = ST_BAD;
					end else begin
						depth_nx = depth_q + DEPTH_BITS'(1);
					end
				end
			end
			CL_CLOSE: begin
				if (!in_object_q) begin
					st = ST_BAD;
				end else begin
					esc_nx = 1'b0;
					if (!in_string_q) begin
						if (depth_q <= DEPTH_BITS'(1)) begin
							depth_nx = '0;
							st       = ST_DONE;
						end else begin
							depth_nx = depth_q - DEPTH_BITS'(1);
						end
					end
				end
			end
			CL_BSLASH: begin
				if (!in_object_q || !in_string_q) begin
					st = ST_BAD;
				end else begin
					esc_nx = !escape_q;
				end
			end
			CL_QUOTE: begin
				if (!in_object_q) begin
					st = ST_BAD;
				end else if (escape_q) begin
					esc_nx = 1'b0;
				end else begin
					str_nx = !in_string_q;
				end
			end
			CL_SKIP: begin
			end
			default: begin
				if (!in_object_q) begin
					st = ST_BAD;
				end else begin
					esc_nx = 1'b0;
				end
			end
		endcase
		if (st == ST_PENDING && count_ext >= max_ext) begin
			st = ST_LONG;
		end
	end

	assign res.status     = st;
	assign res.msg_length = count_ext[MSG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_object_q <= 1'b0;
			in_string_q <= 1'b0;
			escape_q    <= 1'b0;
			depth_q     <= '0;
			count_q     <= '0;
			msg_max_q   <= MSG_MAX_RESET;
		end else begin
			if (msg_max_we) begin
				msg_max_q <= msg_max_wdata;
			end
			if (go) begin
				if (st != ST_PENDING) begin
					in_object_q <= 1'b0;
					in_string_q <= 1'b0;
					escape_q    <= 1'b0;
					depth_q     <= '0;
					count_q     <= '0;
				end else begin
					in_object_q <= obj_nx;
					in_string_q <= str_nx;
					escape_q    <= esc_nx;
					depth_q     <= depth_nx;
					count_q     <= count_nx;
				end
			end
		end
	end
endmodule

### tb/jof_frame_checker.sv
// watches the byte and result channels of the framer, predicts each result and compares
module jof_frame_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic                      full,
	input  logic [7:0]                data_byte,
	input  logic                      empty,
	input  logic                      pop,
	input  logic [1:0]                status,
	input  logic [jof_pkg::MSG_W-1:0] msg_length,
	input  logic                      msg_max_we,
	input  logic [jof_pkg::MSG_W-1:0] msg_max_wdata,
	output int                        mismatches,
	output int                        results_owed
);
	import jof_pkg::*;

	// own copy of the framing state and the length limit
	logic             in_obj;
	logic             in_str;
	logic             esc;
	logic [7:0]       depth;
	logic [15:0]      count;
	logic [MSG_W-1:0] limit;

	result_t owed_q[$];
	result_t want;
	int      errs = 0;

	task automatic clear_framer();
		in_obj = 1'b0;
		in_str = 1'b0;
		esc    = 1'b0;
		depth  = '0;
		count  = '0;
	endtask

	task automatic advance_framer(input logic [7:0] b, output result_t r);
		status_t st;
		st = ST_PENDING;
		if (count != '1)
			count = count + 16'd1;
		r.msg_length = count;
		case (b)
			CH_OPEN: begin
				in_obj = 1'b1;
				if (!in_str) begin
					if (depth == '1)
						st = ST_BAD;
					else
						depth = depth + 8'd1;
				end
				esc = 1'b0;
			end
			CH_CLOSE: begin
				if (!in_obj) begin
					st = ST_BAD;
				end else begin
					esc = 1'b0;
					if (!in_str) begin
						if (depth <= 8'd1) begin
							depth = '0;
							st = ST_DONE;
						end else begin
							depth = depth - 8'd1;
						end
					end
				end
			end
			CH_BSLASH: begin
				if (!in_obj || !in_str)
					st = ST_BAD;
				else
					esc = !esc;
			end
			CH_QUOTE: begin
				if (!in_obj)
					st = ST_BAD;
				else if (esc)
					esc = 1'b0;
				else
					in_str = !in_str;
			end
			CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_NUL: begin
			end
			default: begin
				if (!in_obj)
					st = ST_BAD;
				else
					esc = 1'b0;
			end
		endcase
		if (st == ST_PENDING && count >= limit)
			st = ST_LONG;
		if (st != ST_PENDING)
			clear_framer();
		r.status = st;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_framer();
			limit = MSG_MAX_RESET;
			owed_q.delete();
			results_owed <= 0;
			mismatches <= errs;
		end else begin
			if (msg_max_we)
				limit = msg_max_wdata;
			// result transfer: compare with the oldest prediction
			if (pop && !empty) begin
				if (owed_q.size() == 0) begin
					errs++;
					$display("%0t: result with none expected, status %0d length %0d",
						$time, status, msg_length);
				end else begin
					want = owed_q.pop_front();
					if (status !== want.status) begin
						errs++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
					end
					if (msg_length !== want.msg_length) begin
						errs++;
						$display("%0t: msg_length expected %0d actual %0d",
							$time, want.msg_length, msg_length);
					end
				end
			end
			// byte transfer: predict its result
			if (push && !full) begin
				advance_framer(data_byte, want);
				owed_q.push_back(want);
			end
			mismatches <= errs;
			results_owed <= owed_q.size();
		end
	end

endmodule

### tb/tb_top.sv
// stimulus and verdict for the json object framer, with the checker beside the block
module tb_top;
	import jof_pkg::*;

	// generous bound on the whole run, far above the slowest correct run
	localparam int CYCLE_LIMIT = 600000;
	// bytes of random traffic per phase
	localparam int PHASE_BYTES = 100;
	localparam int N_PHASES    = 6;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic [7:0]       data_byte = 8'h00;
	logic             pop = 1'b0;
	logic             msg_max_we = 1'b0;
	logic [MSG_W-1:0] msg_max_wdata = '0;
	logic             full;
	logic             empty;
	logic [1:0]       status;
	logic [MSG_W-1:0] msg_length;

	int mismatches;
	int results_owed;
	int cycles = 0;

	// idle rates in percent for the current phase
	int send_idle_pct = 0;
	int pop_stall_pct = 0;

	// bytes of the message being built, and bytes sent in the current phase
	logic [7:0] msg_q[$];
	int         sent;

	// per-phase length limit and idle rates: extremes of the limit among them
	logic [MSG_W-1:0] phase_limit[N_PHASES] = '{16'd20, 16'd1, 16'd600, 16'hFFFF, 16'd12, 16'd4096};
	int               phase_send[N_PHASES]  = '{0, 59, 0, 24, 0, 24};
	int               phase_stall[N_PHASES] = '{0, 0, 59, 24, 59, 24};

	logic [7:0] blanks[5] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_NUL};

	json_object_framer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.msg_length    (msg_length),
		.msg_max_we    (msg_max_we),
		.msg_max_wdata (msg_max_wdata)
	);

	jof_frame_checker frame_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.msg_length    (msg_length),
		.msg_max_we    (msg_max_we),
		.msg_max_wdata (msg_max_wdata),
		.mismatches    (mismatches),
		.results_owed  (results_owed)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver side: pop stalls at random at the phase's rate
	always @(posedge clk)
		pop <= ($urandom_range(99) >= pop_stall_pct);

	// cycle counter: a hung block ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// mostly printable text, now and then any byte so every data bit toggles
	function automatic logic [7:0] text_byte();
		if ($urandom_range(99) < 15)
			return 8'($urandom_range(255));
		return 8'($urandom_range(8'h30, 8'h7A));
	endfunction

	// quoted string with escapes, doubled backslashes and braces inside
	function automatic void add_string();
		int n;
		int r;
		msg_q.push_back(CH_QUOTE);
		n = $urandom_range(6);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 20) begin
				msg_q.push_back(CH_BSLASH);
				case ($urandom_range(4))
					0: msg_q.push_back(CH_QUOTE);
					1: msg_q.push_back(CH_BSLASH);
					2: msg_q.push_back(CH_OPEN);
					3: msg_q.push_back(CH_CLOSE);
					default: msg_q.push_back(text_byte());
				endcase
			end else if (r < 30) begin
				msg_q.push_back($urandom_range(1) ? CH_OPEN : CH_CLOSE);
			end else if (r < 36) begin
				msg_q.push_back(blanks[$urandom_range(4)]);
			end else begin
				msg_q.push_back(text_byte());
			end
		end
		msg_q.push_back(CH_QUOTE);
	endfunction

	// balanced object with random content, nested up to eight levels
	function automatic void add_object();
		int lvl;
		int steps;
		int r;
		lvl = 1;
		steps = 0;
		msg_q.push_back(CH_OPEN);
		while (lvl > 0) begin
			r = $urandom_range(99);
			if (steps >= 30 || r < 22) begin
				msg_q.push_back(CH_CLOSE);
				lvl--;
			end else if (r < 38 && lvl < 8) begin
				msg_q.push_back(CH_OPEN);
				lvl++;
			end else if (r < 60) begin
				add_string();
			end else if (r < 75) begin
				msg_q.push_back(blanks[$urandom_range(4)]);
			end else begin
				msg_q.push_back(text_byte());
			end
			steps++;
		end
	endfunction

	// one message: mostly well formed, the rest cut short or plain noise
	function automatic void build_message();
		int r;
		int keep;
		r = $urandom_range(99);
		if ($urandom_range(99) < 30)
			msg_q.push_back(blanks[$urandom_range(4)]);
		if (r < 65) begin
			add_object();
		end else if (r < 80) begin
			add_object();
			keep = $urandom_range(1, msg_q.size());
			while (msg_q.size() > keep)
				void'(msg_q.pop_back());
		end else begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(1))
					case ($urandom_range(5))
						0: msg_q.push_back(CH_OPEN);
						1: msg_q.push_back(CH_CLOSE);
						2: msg_q.push_back(CH_BSLASH);
						3: msg_q.push_back(CH_QUOTE);
						4: msg_q.push_back(CH_SPACE);
						default: msg_q.push_back(CH_NUL);
					endcase
				else
					msg_q.push_back(8'($urandom_range(255)));
			end
		end
	endfunction

	// one byte transfer; push stays high into the next byte unless the sender idles
	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_message();
		while (msg_q.size() != 0)
			put_byte(msg_q.pop_front());
	endtask

	// sender pauses until every predicted result has been popped, then lets the pipe settle
	task automatic wait_results();
		push <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_msg_max(input logic [MSG_W-1:0] v);
		msg_max_we <= 1'b1;
		msg_max_wdata <= v;
		@(posedge clk);
		msg_max_we <= 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset limit:
		// bad bytes before any object, skipped bytes, then escape handling in a string:
		// doubled backslash, brace clearing an escape, skipped byte keeping it,
		// escaped quote, backslash outside a string, and a short complete object
		msg_q = '{8'h61, CH_BSLASH, CH_CLOSE, CH_QUOTE,
			CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF,
			CH_OPEN, CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_CLOSE,
			CH_BSLASH, CH_OPEN, CH_BSLASH, CH_SPACE, CH_QUOTE, CH_QUOTE, CH_BSLASH,
			CH_OPEN, 8'hFF, CH_CLOSE};
		send_message();
		wait_results();

		// random phases, each with its own limit and idle pattern
		for (int p = 0; p < N_PHASES; p++) begin
			write_msg_max(phase_limit[p]);
			send_idle_pct = phase_send[p];
			pop_stall_pct <= phase_stall[p];
			sent = 0;
			if (phase_limit[p] == 16'd600) begin
				// one opening brace past the largest depth
				repeat (256) msg_q.push_back(CH_OPEN);
				send_message();
			end
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_message();
				send_message();
				// now and then a pause in mid phase until all results are back
				if ($urandom_range(99) < 8)
					wait_results();
			end
			wait_results();
		end

		if (mismatches == 0 && results_owed == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### json_object_framer_unit.f
sv/jof_pkg.sv
sv/jof_fifo.sv
sv/jof_front.sv
sv/jof_back.sv
sv/json_object_framer_unit.sv
tb/jof_frame_checker.sv
tb/tb_top.sv
